[src/ght_pkg.sv]
// shared types and constants of the generation handle slot table
`default_nettype none
package ght_pkg;

  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 31;
  localparam int STATUS_W = 2;
  localparam int SLOTO_W  = 10;
  localparam int STATE_W  = 3;

  // request commands
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd3;

  // response status
  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_RUNNABLE = 2'd3;

  // slot life states
  localparam logic [STATE_W-1:0] ST_FREE     = 3'd0;
  localparam logic [STATE_W-1:0] ST_RUNNABLE = 3'd2;
  localparam logic [STATE_W-1:0] ST_RUNNING  = 3'd3;

  // generation increment, kept above the slot bits
  localparam logic [31:0] GEN_STEP = 32'd4096;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } ght_ctl_t;

endpackage
`default_nettype wire

[src/ght_if.sv]
// request and response channel interfaces
`default_nettype none
interface ght_req_if;
  logic                           valid;
  logic                           ready;
  logic [ght_pkg::CMD_W-1:0]      cmd;
  logic [ght_pkg::HANDLE_W-1:0]   handle_in;
  logic [ght_pkg::HANDLE_W-1:0]   parent_handle;
  logic                           check_permission;

  modport source (output valid, cmd, handle_in, parent_handle, check_permission,
                  input ready);
  modport sink (input valid, cmd, handle_in, parent_handle, check_permission,
                output ready);
endinterface

interface ght_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ght_pkg::STATUS_W-1:0]   status;
  logic [ght_pkg::HANDLE_W-1:0]   handle_out;
  logic [ght_pkg::SLOTO_W-1:0]    slot_index;
  logic [ght_pkg::STATE_W-1:0]    slot_state;

  modport source (output valid, status, handle_out, slot_index, slot_state,
                  input ready);
  modport sink (input valid, status, handle_out, slot_index, slot_state,
                output ready);
endinterface
`default_nettype wire

[src/ght_ctrl.sv]
// request sequencing state machine and response valid flag
`default_nettype none
module ght_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output ght_pkg::ght_ctl_t      ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    ctl.capture = 1'b0;
    ctl.execute = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        ctl.capture = req_valid;
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        // wait for the response register to be free
        ctl.execute = !rsp_valid || rsp_ready;
        if (ctl.execute) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (ctl.execute) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
`default_nettype wire

[src/ght_datapath.sv]
// slot memories, free stack, current slot and response registers
`default_nettype none
module ght_datapath #(
  parameter int SLOTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ght_pkg::ght_ctl_t             ctl,
  input  wire logic [ght_pkg::CMD_W-1:0]     req_cmd,
  input  wire logic [ght_pkg::HANDLE_W-1:0]  req_handle,
  input  wire logic [ght_pkg::HANDLE_W-1:0]  req_parent,
  input  wire logic                          req_check,
  output logic [ght_pkg::STATUS_W-1:0]       status,
  output logic [ght_pkg::HANDLE_W-1:0]       handle_out,
  output logic [ght_pkg::SLOTO_W-1:0]        slot_index,
  output logic [ght_pkg::STATE_W-1:0]        slot_state
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW   = $clog2(SLOTS + 1);
  localparam logic [LW-1:0]   SLOTS_L  = LW'(SLOTS);
  localparam logic [IDXW-1:0] IDX_MASK = IDXW'(SLOTS - 1);
  localparam logic [31:0]     GEN_MASK = ~(32'(SLOTS - 1));

  localparam int HW = ght_pkg::HANDLE_W;
  localparam int SW = ght_pkg::STATE_W;

  // slot memories
  logic [HW-1:0] handle_mem [SLOTS];
  logic [SW-1:0] state_mem  [SLOTS];
  logic [HW-1:0] parent_mem [SLOTS];
  logic [31:0]   count_mem  [SLOTS];
  logic [LW-1:0] link_mem   [SLOTS];

  // table registers
  logic [LW-1:0] free_head;
  logic [LW-1:0] current_slot;
  logic [HW-1:0] current_handle;
  logic [SW-1:0] current_state;
  logic [LW-1:0] fill;

  // captured request
  logic [ght_pkg::CMD_W-1:0] q_cmd;
  logic [HW-1:0]             q_handle;
  logic [HW-1:0]             q_parent;
  logic                      q_check;
  logic [IDXW-1:0]           q_idx;
  logic                      q_valid;
  logic                      q_range;
  logic                      q_zero;
  logic                      q_empty;

  // registered memory reads
  logic [HW-1:0] rd_handle;
  logic [SW-1:0] rd_state;
  logic [HW-1:0] rd_parent;
  logic [31:0]   rd_count;
  logic [LW-1:0] rd_link;

  // read address selection at capture
  logic            a_zero;
  logic [IDXW-1:0] a_idx;

  always_comb begin
    a_zero = (req_handle == '0);
    if (req_cmd == ght_pkg::CMD_ALLOC) a_idx = free_head[IDXW-1:0];
    else if (a_zero) a_idx = current_slot[IDXW-1:0];
    else a_idx = req_handle[IDXW-1:0] & IDX_MASK;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      q_cmd    <= req_cmd;
      q_handle <= req_handle;
      q_parent <= req_parent;
      q_check  <= req_check;
      q_idx    <= a_idx;
      q_zero   <= a_zero;
      q_valid  <= (LW'(a_idx) < fill);
      q_range  <= (LW'(a_idx) < SLOTS_L);
      q_empty  <= (free_head == SLOTS_L);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      rd_handle <= handle_mem[a_idx];
      rd_state  <= state_mem[a_idx];
      rd_parent <= parent_mem[a_idx];
      rd_count  <= count_mem[a_idx];
      rd_link   <= link_mem[a_idx];
    end
  end

  // execute step
  logic            have_cur;
  logic            is_cur;
  logic [HW-1:0]   e_handle;
  logic [SW-1:0]   e_state;
  logic [HW-1:0]   e_parent;
  logic [LW-1:0]   e_link;
  logic            resolved;
  logic [31:0]     gen_sum;
  logic [31:0]     gen;
  logic [HW-1:0]   new_handle;
  logic [SW-1:0]   tstate;

  logic [ght_pkg::STATUS_W-1:0] r_status;
  logic [HW-1:0]                r_handle;
  logic [IDXW-1:0]              r_idx;
  logic [SW-1:0]                r_state;

  logic            we_handle, we_state, we_parent, we_count, we_link;
  logic [IDXW-1:0] state_waddr;
  logic [SW-1:0]   state_wdata;
  logic [31:0]     count_wdata;

  logic [LW-1:0] free_head_next;
  logic [LW-1:0] current_slot_next;
  logic [HW-1:0] current_handle_next;
  logic [SW-1:0] current_state_next;
  logic [LW-1:0] fill_next;

  always_comb begin
    have_cur = (current_slot != SLOTS_L);
    is_cur   = have_cur && (LW'(q_idx) == current_slot);
    // slots at or above the fill count were never written and read as reset values
    e_handle = q_valid ? rd_handle : '0;
    e_parent = q_valid ? rd_parent : '0;
    e_link   = q_valid ? rd_link : LW'(q_idx) + LW'(1);
    // the current slot's state lives in a register
    if (is_cur) e_state = current_state;
    else if (q_valid) e_state = rd_state;
    else e_state = ght_pkg::ST_FREE;

    resolved = q_zero ? have_cur
                      : (q_range && e_state != ght_pkg::ST_FREE && e_handle == q_handle);

    gen_sum = {1'b0, e_handle} + ght_pkg::GEN_STEP;
    gen     = gen_sum & GEN_MASK;
    if (gen == '0 || gen[31]) gen = ght_pkg::GEN_STEP;
    new_handle = HW'(gen | 32'(q_idx));

    tstate = e_state;
    if (is_cur && tstate == ght_pkg::ST_RUNNING) tstate = ght_pkg::ST_RUNNABLE;

    r_status = ght_pkg::STATUS_BAD_HANDLE;
    r_handle = '0;
    r_idx    = '0;
    r_state  = ght_pkg::ST_FREE;

    we_handle   = 1'b0;
    we_state    = 1'b0;
    we_parent   = 1'b0;
    we_count    = 1'b0;
    we_link     = 1'b0;
    state_waddr = q_idx;
    state_wdata = ght_pkg::ST_FREE;
    count_wdata = '0;

    free_head_next      = free_head;
    current_slot_next   = current_slot;
    current_handle_next = current_handle;
    current_state_next  = current_state;
    fill_next           = fill;

    case (q_cmd)
      ght_pkg::CMD_ALLOC: begin
        if (q_empty) begin
          r_status = ght_pkg::STATUS_NO_FREE;
        end else begin
          r_status       = ght_pkg::STATUS_OK;
          r_handle       = new_handle;
          r_idx          = q_idx;
          r_state        = ght_pkg::ST_RUNNABLE;
          we_handle      = 1'b1;
          we_parent      = 1'b1;
          we_state       = 1'b1;
          state_wdata    = ght_pkg::ST_RUNNABLE;
          we_count       = 1'b1;
          free_head_next = e_link;
          if (!q_valid) fill_next = fill + LW'(1);
        end
      end
      ght_pkg::CMD_LOOKUP: begin
        if (q_zero) begin
          r_status = ght_pkg::STATUS_OK;
          if (have_cur) begin
            r_handle = current_handle;
            r_idx    = current_slot[IDXW-1:0];
            r_state  = current_state;
          end
        end else if (resolved && !(q_check && LW'(q_idx) != current_slot &&
                                  (!have_cur || e_parent != current_handle))) begin
          r_status = ght_pkg::STATUS_OK;
          r_handle = e_handle;
          r_idx    = q_idx;
          r_state  = e_state;
        end
      end
      ght_pkg::CMD_FREE: begin
        if (resolved) begin
          r_status       = ght_pkg::STATUS_OK;
          r_handle       = e_handle;
          r_idx          = q_idx;
          r_state        = ght_pkg::ST_FREE;
          we_state       = 1'b1;
          state_wdata    = ght_pkg::ST_FREE;
          we_link        = 1'b1;
          free_head_next = LW'(q_idx);
          if (is_cur) current_slot_next = SLOTS_L;
        end
      end
      ght_pkg::CMD_RUN: begin
        if (resolved) begin
          r_handle = e_handle;
          r_idx    = q_idx;
          if (tstate != ght_pkg::ST_RUNNABLE) begin
            r_status = ght_pkg::STATUS_NOT_RUNNABLE;
            r_state  = e_state;
          end else begin
            r_status = ght_pkg::STATUS_OK;
            r_state  = ght_pkg::ST_RUNNING;
            // write back the outgoing current slot's state, demoted if running
            if (have_cur && !is_cur) begin
              we_state    = 1'b1;
              state_waddr = current_slot[IDXW-1:0];
              state_wdata = (current_state == ght_pkg::ST_RUNNING) ?
                            ght_pkg::ST_RUNNABLE : current_state;
            end
            we_count            = 1'b1;
            count_wdata         = rd_count + 32'd1;
            current_slot_next   = LW'(q_idx);
            current_handle_next = e_handle;
            current_state_next  = ght_pkg::ST_RUNNING;
          end
        end
      end
      default: r_status = ght_pkg::STATUS_BAD_HANDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      if (we_handle) handle_mem[q_idx] <= new_handle;
      if (we_parent) parent_mem[q_idx] <= q_parent;
      if (we_state) state_mem[state_waddr] <= state_wdata;
      if (we_count) count_mem[q_idx] <= count_wdata;
      if (we_link) link_mem[q_idx] <= free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head      <= '0;
      current_slot   <= SLOTS_L;
      current_handle <= '0;
      current_state  <= ght_pkg::ST_FREE;
      fill           <= '0;
    end else if (ctl.execute) begin
      free_head      <= free_head_next;
      current_slot   <= current_slot_next;
      current_handle <= current_handle_next;
      current_state  <= current_state_next;
      fill           <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status     <= r_status;
      handle_out <= r_handle;
      slot_index <= ght_pkg::SLOTO_W'(r_idx);
      slot_state <= r_state;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= SLOTS_L)
    else $error("fill count beyond table size");
  a_head_bound: assert property (@(posedge clk) disable iff (rst) free_head <= SLOTS_L)
    else $error("free stack head beyond table size");
  a_cur_touched: assert property (@(posedge clk) disable iff (rst)
    (current_slot != SLOTS_L) |-> (current_slot < fill))
    else $error("current slot was never allocated");
  a_cur_not_free: assert property (@(posedge clk) disable iff (rst)
    (current_slot != SLOTS_L) |-> (free_head != current_slot))
    else $error("current slot sits at the free stack head");

endmodule
`default_nettype wire

[src/generation_handle_slot_table_unit.sv]
// top level of the generation handle slot table
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------------
//  req     | in  | valid / ready | cmd, handle_in, parent_handle, check_permission
//  rsp     | out | valid / ready | status, handle_out, slot_index, slot_state
//
// each request is captured, which reads the slot memories, and then executed,
// which updates the slot entry, free stack and current slot and loads the response
// register; the slot memories see a single read-modify-write per request
// reset is ready at once: slots at or above a fill count read as never allocated
// a response waiting in its register does not block capture of the next request;
// that request then waits in its execute step until the response is taken
`default_nettype none
module generation_handle_slot_table_unit #(
  parameter int SLOTS = 1024
) (
  input wire logic clk,
  input wire logic rst,
  ght_req_if.sink  req,
  ght_rsp_if.source rsp
);

  // controller commands towards the datapath
  ght_pkg::ght_ctl_t ctl;

  // sequencing: capture, then execute when the response register is free
  ght_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl)
  );

  // slot memories and table registers
  ght_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .req_cmd    (req.cmd),
    .req_handle (req.handle_in),
    .req_parent (req.parent_handle),
    .req_check  (req.check_permission),
    .status     (rsp.status),
    .handle_out (rsp.handle_out),
    .slot_index (rsp.slot_index),
    .slot_state (rsp.slot_state)
  );

endmodule
`default_nettype wire

[bench/generation_handle_slot_table_unit_tb.sv]
// testbench of the generation handle slot table: request stream against a slot table predictor
`default_nettype none
module generation_handle_slot_table_unit_tb;

  localparam int SLOTS = 1024;
  localparam logic [10:0] NO_SLOT = 11'(SLOTS);
  localparam int HW = ght_pkg::HANDLE_W;
  // well over ten times the slowest run: ~1200 requests with their source and sink idle gaps,
  // and one long hold
  localparam int WATCHDOG = 10_000_000;

  // one response as the table should give it
  typedef struct packed {
    logic [ght_pkg::STATUS_W-1:0] status;
    logic [ght_pkg::HANDLE_W-1:0] handle;
    logic [ght_pkg::SLOTO_W-1:0]  slot;
    logic [ght_pkg::STATE_W-1:0]  state;
  } table_reply_t;

  logic clk;
  logic rst;

  ght_req_if req_ch ();
  ght_rsp_if rsp_ch ();

  generation_handle_slot_table_unit #(.SLOTS(SLOTS)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predicted slot table, kept in step with every accepted request
  logic [HW-1:0]                slot_handle [SLOTS];
  logic [ght_pkg::STATE_W-1:0]  slot_life   [SLOTS];
  logic [HW-1:0]                slot_parent [SLOTS];
  logic [31:0]                  slot_runs   [SLOTS];
  logic [10:0]                  slot_link   [SLOTS];
  logic [10:0]                  free_top;
  logic [10:0]                  active_slot;

  // bookkeeping that steers the stimulus towards live and stale handles
  int unsigned   live_slots [$];
  logic [HW-1:0] retired_handles [$];

  table_reply_t pending_replies [$];
  table_reply_t last_reply;
  int           mismatch_count;

  // idling controls, changed between tests
  bit source_idle;
  bit sink_idle;
  int hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_handle[i] = '0;
      slot_life[i]   = ght_pkg::ST_FREE;
      slot_parent[i] = '0;
      slot_runs[i]   = '0;
      slot_link[i]   = 11'(i + 1);
    end
    free_top    = '0;
    active_slot = NO_SLOT;
    live_slots.delete();
    retired_handles.delete();
  endtask

  function automatic bit have_active();
    return active_slot < NO_SLOT;
  endfunction

  // apply one request to the predicted table and give the response it must cause
  function automatic table_reply_t table_step(logic [ght_pkg::CMD_W-1:0] c, logic [HW-1:0] h,
                                              logic [HW-1:0] p, logic k);
    table_reply_t r;
    logic [31:0]  gen;
    logic [10:0]  idx;
    logic [ght_pkg::STATE_W-1:0] tstate;
    bit           found;
    r = '0;
    idx = '0;
    found = 1'b0;

    if (c == ght_pkg::CMD_ALLOC) begin
      if (free_top >= NO_SLOT) begin
        r.status = ght_pkg::STATUS_NO_FREE;
        return r;
      end
      idx = free_top;
      // next generation above the slot bits, restarting at one step on overflow or zero
      gen = ({1'b0, slot_handle[idx]} + ght_pkg::GEN_STEP) & ~(32'(SLOTS - 1));
      if (gen == '0 || gen[31])
        gen = ght_pkg::GEN_STEP;
      slot_handle[idx] = gen[HW-1:0] | HW'(idx);
      slot_parent[idx] = p;
      slot_life[idx]   = ght_pkg::ST_RUNNABLE;
      slot_runs[idx]   = '0;
      free_top         = slot_link[idx];
      live_slots.push_back(idx);
      r = '{ght_pkg::STATUS_OK, slot_handle[idx], ght_pkg::SLOTO_W'(idx),
            ght_pkg::ST_RUNNABLE};
      return r;
    end

    // resolve the handle: zero stands for the current slot
    if (h == '0) begin
      found = have_active();
      idx   = active_slot;
    end else begin
      idx   = 11'(h & HW'(SLOTS - 1));
      found = idx < NO_SLOT && slot_life[idx] != ght_pkg::ST_FREE && slot_handle[idx] == h;
    end

    if (c == ght_pkg::CMD_LOOKUP) begin
      if (h == '0) begin
        if (found)
          r = '{ght_pkg::STATUS_OK, slot_handle[idx], ght_pkg::SLOTO_W'(idx), slot_life[idx]};
        return r;
      end
      if (!found) begin
        r.status = ght_pkg::STATUS_BAD_HANDLE;
        return r;
      end
      // permission: target must be the current slot or a child of it
      if (k && idx != active_slot &&
          (!have_active() || slot_parent[idx] != slot_handle[active_slot])) begin
        r.status = ght_pkg::STATUS_BAD_HANDLE;
        return r;
      end
      r = '{ght_pkg::STATUS_OK, slot_handle[idx], ght_pkg::SLOTO_W'(idx), slot_life[idx]};
      return r;
    end

    if (!found) begin
      r.status = ght_pkg::STATUS_BAD_HANDLE;
      return r;
    end

    if (c == ght_pkg::CMD_FREE) begin
      slot_life[idx] = ght_pkg::ST_FREE;
      slot_link[idx] = free_top;
      free_top       = idx;
      if (active_slot == idx)
        active_slot = NO_SLOT;
      for (int i = 0; i < live_slots.size(); i++) begin
        if (live_slots[i] == idx) begin
          live_slots.delete(i);
          break;
        end
      end
      retired_handles.push_back(slot_handle[idx]);
      if (retired_handles.size() > 64)
        void'(retired_handles.pop_front());
      r = '{ght_pkg::STATUS_OK, slot_handle[idx], ght_pkg::SLOTO_W'(idx), ght_pkg::ST_FREE};
      return r;
    end

    // run: a running current slot counts as runnable for its own rerun
    tstate = slot_life[idx];
    if (idx == active_slot && tstate == ght_pkg::ST_RUNNING)
      tstate = ght_pkg::ST_RUNNABLE;
    if (tstate != ght_pkg::ST_RUNNABLE) begin
      r = '{ght_pkg::STATUS_NOT_RUNNABLE, slot_handle[idx], ght_pkg::SLOTO_W'(idx),
            slot_life[idx]};
      return r;
    end
    if (have_active() && slot_life[active_slot] == ght_pkg::ST_RUNNING)
      slot_life[active_slot] = ght_pkg::ST_RUNNABLE;
    active_slot    = idx;
    slot_life[idx] = ght_pkg::ST_RUNNING;
    slot_runs[idx] = slot_runs[idx] + 32'd1;
    r = '{ght_pkg::STATUS_OK, slot_handle[idx], ght_pkg::SLOTO_W'(idx), ght_pkg::ST_RUNNING};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request, wait for it to be taken, then predict its response;
  // entered and left on a rising edge, valid stays high if the next gap is zero
  task automatic send_request(logic [ght_pkg::CMD_W-1:0] c, logic [HW-1:0] h,
                              logic [HW-1:0] p, logic k);
    int gap;
    gap = source_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.cmd              <= c;
    req_ch.handle_in        <= h;
    req_ch.parent_handle    <= p;
    req_ch.check_permission <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    last_reply = table_step(c, h, p, k);
    pending_replies.push_back(last_reply);
  endtask

  // handle to aim at: mostly live ones, some zero, stale or pure noise
  function automatic logic [HW-1:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70 && live_slots.size() > 0)
      return slot_handle[live_slots[$urandom_range(0, live_slots.size() - 1)]];
    if (roll < 80)
      return '0;
    if (roll < 90 && retired_handles.size() > 0)
      return retired_handles[$urandom_range(0, retired_handles.size() - 1)];
    return HW'($urandom());
  endfunction

  // parent for allocate: often the current slot so permission checks can pass
  function automatic logic [HW-1:0] pick_parent();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && have_active())
      return slot_handle[active_slot];
    if (roll < 70 && live_slots.size() > 0)
      return slot_handle[live_slots[$urandom_range(0, live_slots.size() - 1)]];
    return HW'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // response side
  // ---------------------------------------------------------------------------

  // receiver: random stall before each response, plus a long hold when asked
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = sink_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // every taken response against the oldest prediction
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("response with no request pending", 32'(rsp_ch.status), 32'd0);
      end else begin
        want = pending_replies.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.handle_out !== want.handle)
          report_mismatch("handle_out", 32'(rsp_ch.handle_out), 32'(want.handle));
        if (rsp_ch.slot_index !== want.slot)
          report_mismatch("slot_index", 32'(rsp_ch.slot_index), 32'(want.slot));
        if (rsp_ch.slot_state !== want.state)
          report_mismatch("slot_state", 32'(rsp_ch.slot_state), 32'(want.state));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked sequence: empty table, parenthood, run and demotion, reuse, stale handles
  task automatic test_directed();
    logic [HW-1:0] h_a, h_b, h_c, h_b_new;
    // nothing current yet
    send_request(ght_pkg::CMD_LOOKUP, '0, '0, 1'b0);
    send_request(ght_pkg::CMD_LOOKUP, 31'h7FFF_FFFF, '0, 1'b1);
    send_request(ght_pkg::CMD_FREE, '0, '0, 1'b0);
    send_request(ght_pkg::CMD_RUN, '0, '0, 1'b0);
    // two slots, the second a child of the first
    send_request(ght_pkg::CMD_ALLOC, '0, '0, 1'b0);
    h_a = last_reply.handle;
    send_request(ght_pkg::CMD_ALLOC, '0, h_a, 1'b0);
    h_b = last_reply.handle;
    // permission check with no current slot must fail
    send_request(ght_pkg::CMD_LOOKUP, h_b, '0, 1'b1);
    send_request(ght_pkg::CMD_RUN, h_a, '0, 1'b0);
    send_request(ght_pkg::CMD_LOOKUP, h_b, '0, 1'b1);
    send_request(ght_pkg::CMD_LOOKUP, '0, '0, 1'b1);
    // a slot whose parent is not current
    send_request(ght_pkg::CMD_ALLOC, '0, 31'h7FFF_FFFF, 1'b0);
    h_c = last_reply.handle;
    send_request(ght_pkg::CMD_LOOKUP, h_c, '0, 1'b1);
    // switch to the child, then rerun it while it is running
    send_request(ght_pkg::CMD_RUN, h_b, '0, 1'b0);
    send_request(ght_pkg::CMD_RUN, h_b, '0, 1'b0);
    send_request(ght_pkg::CMD_LOOKUP, h_a, '0, 1'b0);
    // freeing the current slot leaves no current
    send_request(ght_pkg::CMD_FREE, '0, '0, 1'b0);
    send_request(ght_pkg::CMD_LOOKUP, h_b, '0, 1'b0);
    send_request(ght_pkg::CMD_LOOKUP, '0, '0, 1'b0);
    // reuse bumps the generation, the old handle is now stale
    send_request(ght_pkg::CMD_ALLOC, '0, '0, 1'b0);
    h_b_new = last_reply.handle;
    send_request(ght_pkg::CMD_FREE, h_b, '0, 1'b0);
    send_request(ght_pkg::CMD_RUN, 31'h7FFF_FFFF, '0, 1'b0);
    send_request(ght_pkg::CMD_FREE, h_a, '0, 1'b0);
    send_request(ght_pkg::CMD_FREE, h_c, '0, 1'b0);
    send_request(ght_pkg::CMD_FREE, h_b_new, '0, 1'b0);
  endtask

  // mostly well-formed traffic on live handles, with stale and noisy ones mixed in
  task automatic test_random_mix(int count);
    int roll;
    logic [ght_pkg::CMD_W-1:0] c;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 28)
        c = ght_pkg::CMD_ALLOC;
      else if (roll < 58)
        c = ght_pkg::CMD_LOOKUP;
      else if (roll < 78)
        c = ght_pkg::CMD_FREE;
      else
        c = ght_pkg::CMD_RUN;
      // keep the table small so handles get reused and go stale
      if (c == ght_pkg::CMD_ALLOC && live_slots.size() > 48)
        c = ght_pkg::CMD_FREE;
      send_request(c, pick_handle(), pick_parent(), 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    source_idle = 1'b0;
    hold_off_cycles = 80;
    test_random_mix(30);
    source_idle = 1'b1;
  endtask

  // fill every slot, hit the empty free stack, then give some back
  task automatic test_table_full();
    int guard;
    guard = 0;
    last_reply = '0;
    while (last_reply.status != ght_pkg::STATUS_NO_FREE && guard < SLOTS + 8) begin
      send_request(ght_pkg::CMD_ALLOC, pick_parent(), HW'($urandom()), 1'b0);
      guard++;
    end
    send_request(ght_pkg::CMD_ALLOC, '0, '0, 1'b0);
    send_request(ght_pkg::CMD_RUN, pick_handle(), '0, 1'b0);
    send_request(ght_pkg::CMD_LOOKUP, pick_handle(), '0, 1'b1);
    for (int n = 0; n < 40 && live_slots.size() > 0; n++)
      send_request(ght_pkg::CMD_FREE,
                   slot_handle[live_slots[$urandom_range(0, live_slots.size() - 1)]],
                   '0, 1'b0);
    send_request(ght_pkg::CMD_ALLOC, '0, '0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    mismatch_count  = 0;
    hold_off_cycles = 0;
    source_idle     = 1'b1;
    sink_idle       = 1'b1;
    rst                     <= 1'b1;
    req_ch.valid            <= 1'b0;
    req_ch.cmd              <= ght_pkg::CMD_ALLOC;
    req_ch.handle_in        <= '0;
    req_ch.parent_handle    <= '0;
    req_ch.check_permission <= 1'b0;
    clear_table();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_pressure();
    test_random_mix(40);
    // a stretch with neither side idling
    source_idle = 1'b0;
    sink_idle   = 1'b0;
    test_random_mix(30);
    source_idle = 1'b1;
    test_table_full();
    sink_idle = 1'b1;
    test_random_mix(20);

    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // allow for a stray response after the last expected one
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("PASS generation_handle_slot_table_unit");
    end else begin
      $display("FAIL generation_handle_slot_table_unit");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(WATCHDOG);
    $display("FAIL generation_handle_slot_table_unit");
    $finish;
  end

endmodule
`default_nettype wire
